### rtl/mcsp_pkg.sv
// ----------------------------------------------------------------------------
// mcsp_pkg
// Shared types and constants of the multi-channel servo pulse generator.
// ----------------------------------------------------------------------------
`default_nettype none

package mcsp_pkg;

    localparam int POS_W  = 16;
    localparam int CHAN_W = 8;
    localparam int PIN_W  = 8;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam int               DEF_CHANNELS     = 8;
    localparam logic [POS_W-1:0] DEF_CENTER_PULSE = 16'd150;

    localparam logic [POS_W-1:0] MIN_PULSE_RESET    = 16'd100;
    localparam logic [POS_W-1:0] MAX_PULSE_RESET    = 16'd200;
    localparam logic [POS_W-1:0] FRAME_LENGTH_RESET = 16'd2000;

    // Register indexes, taken from paddr[3:2].
    typedef enum logic [1:0] {
        REG_MIN_PULSE    = 2'd0,
        REG_MAX_PULSE    = 2'd1,
        REG_FRAME_LENGTH = 2'd2,
        REG_NONE         = 2'd3
    } reg_index_t;

    // Input item.
    typedef struct packed {
        logic              action;
        logic [CHAN_W-1:0] channel;
        logic [POS_W-1:0]  position;
    } item_t;

    // Result item.
    typedef struct packed {
        logic [PIN_W-1:0] pin_levels;
        logic             frame_start;
    } result_t;

    // Command broadcast to every channel cell for one accepted item.
    typedef struct packed {
        logic              tick;
        logic              restart;
        logic              fall_en;
        logic [POS_W-1:0]  count;
        logic              write;
        logic [CHAN_W-1:0] channel;
        logic [POS_W-1:0]  position;
    } cell_cmd_t;

endpackage

`default_nettype wire

### rtl/mcsp_cell.sv
// ----------------------------------------------------------------------------
// mcsp_cell
// One servo channel: stored position, output level, and its place in the
// level chain that collects every channel's next level.
// ----------------------------------------------------------------------------
`default_nettype none

module mcsp_cell #(
    parameter int                      CHANNELS     = mcsp_pkg::DEF_CHANNELS,
    parameter int                      INDEX        = 0,
    parameter logic [mcsp_pkg::POS_W-1:0] CENTER_PULSE = mcsp_pkg::DEF_CENTER_PULSE
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire mcsp_pkg::cell_cmd_t  cmd,
    input  wire logic [CHANNELS-1:0]  levels_in,
    output logic      [CHANNELS-1:0]  levels_out
);
    import mcsp_pkg::*;

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic             level_reg;
    logic             level_next;

    always_comb
    begin
        pos_next   = pos_reg;
        level_next = level_reg;
        if (cmd.write && (cmd.channel == CHAN_W'(INDEX)))
        begin
            pos_next = cmd.position;
        end
        if (cmd.tick)
        begin
            if (cmd.restart)
            begin
                level_next = 1'b1;
            end
            else if (cmd.fall_en && (pos_reg == cmd.count))
            begin
                level_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        levels_out        = levels_in;
        levels_out[INDEX] = level_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= CENTER_PULSE;
            level_reg <= 1'b1;
        end
        else
        begin
            pos_reg   <= pos_next;
            level_reg <= level_next;
        end
    end

endmodule

`default_nettype wire

### rtl/multi_channel_servo_pulse_generator.sv
// ----------------------------------------------------------------------------
// multi_channel_servo_pulse_generator
// Servo pulse generator: one shared tick counter and a chain of channel cells.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                               Direction  Transfer when
//  item      item_valid, item_stall, item          in         valid && !stall
//  result    result_valid, result_stall, result    out        valid && !stall
//  config    psel, penable, pwrite, paddr, pwdata  in         psel && penable
//            prdata, pready                                   && pwrite
//
// An item is accepted, the counter and all cells update at that edge, and
// its result sits in the output buffer on the next cycle. One item can be
// accepted in every cycle while item_stall is low; each cell compares its
// position against the shared counter combinationally.
// A two-entry output buffer (output register plus skid register) lets the
// block keep taking items while one result waits; item_stall is high only
// when both entries are full.
// Reset is asynchronous and active low: the counter clears, every position
// returns to the center value, every pin goes high, and the buffer empties.
//
// ----------------------------------------------------------------------------
`default_nettype none

module multi_channel_servo_pulse_generator #(
    parameter int                         CHANNELS     = mcsp_pkg::DEF_CHANNELS,
    parameter logic [mcsp_pkg::POS_W-1:0] CENTER_PULSE = mcsp_pkg::DEF_CENTER_PULSE
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    input  wire logic                          item_valid,
    output logic                               item_stall,
    input  wire mcsp_pkg::item_t               item,

    output logic                               result_valid,
    input  wire logic                          result_stall,
    output mcsp_pkg::result_t                  result,

    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [mcsp_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [mcsp_pkg::DATA_W-1:0]   pwdata,
    output logic      [mcsp_pkg::DATA_W-1:0]   prdata,
    output logic                               pready
);
    import mcsp_pkg::*;

    // Configuration registers.
    logic [POS_W-1:0] min_pulse_reg;
    logic [POS_W-1:0] max_pulse_reg;
    logic [POS_W-1:0] frame_length_reg;
    logic             cfg_write;
    reg_index_t       cfg_index;

    // Shared tick counter.
    logic [POS_W-1:0] tick_count_reg;
    logic [POS_W-1:0] tick_count_next;
    logic [POS_W-1:0] count_inc;

    // Output buffer.
    result_t          result_reg;
    logic             result_valid_reg;
    result_t          skid_reg;
    logic             skid_valid_reg;

    logic             item_accept;
    logic             result_pop;
    cell_cmd_t        cmd;
    logic [POS_W-1:0] clamped;
    logic [CHANNELS-1:0] levels_chain [0:CHANNELS];
    logic [PIN_W-1:0] pins;
    result_t          result_new;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = reg_index_t'(paddr[3:2]);

    always_comb
    begin
        unique case (cfg_index)
            REG_MIN_PULSE:    prdata = DATA_W'(min_pulse_reg);
            REG_MAX_PULSE:    prdata = DATA_W'(max_pulse_reg);
            REG_FRAME_LENGTH: prdata = DATA_W'(frame_length_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_pulse_reg    <= MIN_PULSE_RESET;
            max_pulse_reg    <= MAX_PULSE_RESET;
            frame_length_reg <= FRAME_LENGTH_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_MIN_PULSE:    min_pulse_reg    <= pwdata[POS_W-1:0];
                REG_MAX_PULSE:    max_pulse_reg    <= pwdata[POS_W-1:0];
                REG_FRAME_LENGTH: frame_length_reg <= pwdata[POS_W-1:0];
                default:          ;
            endcase
        end
    end

    // The block only stalls when both buffer entries hold results.
    assign item_stall  = skid_valid_reg;
    assign item_accept = item_valid && !skid_valid_reg;
    assign result_pop  = result_valid_reg && !result_stall;

    // The counter wraps at 16 bits; the frame restarts only on an exact match.
    assign count_inc = tick_count_reg + POS_W'(1);

    // Below the minimum wins over above the maximum.
    always_comb
    begin
        priority if (item.position < min_pulse_reg)
        begin
            clamped = min_pulse_reg;
        end
        else if (item.position > max_pulse_reg)
        begin
            clamped = max_pulse_reg;
        end
        else
        begin
            clamped = item.position;
        end
    end

    always_comb
    begin
        cmd.tick     = item_accept && !item.action;
        cmd.restart  = (count_inc == frame_length_reg);
        cmd.fall_en  = (count_inc >= min_pulse_reg);
        cmd.count    = count_inc;
        // A write to a channel beyond the last cell is dropped here.
        cmd.write    = item_accept && item.action && (item.channel < CHAN_W'(CHANNELS));
        cmd.channel  = item.channel;
        cmd.position = clamped;
    end

    always_comb
    begin
        tick_count_next = tick_count_reg;
        if (cmd.tick)
        begin
            tick_count_next = cmd.restart ? '0 : count_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg <= '0;
        end
        else
        begin
            tick_count_reg <= tick_count_next;
        end
    end

    // Each cell adds its next level to the vector handed on by its neighbor.
    assign levels_chain[0] = '0;

    for (genvar i = 0; i < CHANNELS; i++)
    begin : g_cell
        mcsp_cell #(
            .CHANNELS     (CHANNELS),
            .INDEX        (i),
            .CENTER_PULSE (CENTER_PULSE)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .levels_in  (levels_chain[i]),
            .levels_out (levels_chain[i+1])
        );
    end

    // Pins beyond the channel count read as low; channels beyond the pin
    // count are kept but not shown.
    for (genvar b = 0; b < PIN_W; b++)
    begin : g_pin
        if (b < CHANNELS)
        begin : g_used
            assign pins[b] = levels_chain[CHANNELS][b];
        end
        else
        begin : g_unused
            assign pins[b] = 1'b0;
        end
    end

    assign result_new.pin_levels  = pins;
    assign result_new.frame_start = cmd.tick && cmd.restart;

    // Output register with a skid entry behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end
        else if (!result_valid_reg || result_pop)
        begin
            result_valid_reg <= skid_valid_reg || item_accept;
            skid_valid_reg   <= 1'b0;
        end
        else if (item_accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!result_valid_reg || result_pop)
        begin
            if (skid_valid_reg)
            begin
                result_reg <= skid_reg;
            end
            else if (item_accept)
            begin
                result_reg <= result_new;
            end
        end
        else if (item_accept)
        begin
            skid_reg <= result_new;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // The skid entry is only ever filled behind a waiting result.
    a_skid_behind_result : assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> result_valid_reg)
        else $error("skid entry holds a result while the output register is empty");

    // A tick that restarts the frame leaves the counter at zero.
    a_restart_clears_count : assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.tick && cmd.restart) |=> (tick_count_reg == '0))
        else $error("counter not cleared after a frame restart");

    // A position write never moves the counter.
    a_write_keeps_count : assert property (@(posedge clk) disable iff (!rst_n)
        (item_accept && item.action) |=> $stable(tick_count_reg))
        else $error("counter changed on a position write");

    // Every accepted item produces a result in the buffer on the next cycle.
    a_accept_fills_buffer : assert property (@(posedge clk) disable iff (!rst_n)
        item_accept |=> result_valid_reg)
        else $error("accepted item left no result in the output buffer");

endmodule

`default_nettype wire

### sim/tb_multi_channel_servo_pulse_generator.sv
// ----------------------------------------------------------------------------
// tb_multi_channel_servo_pulse_generator
// Self-checking testbench for the multi-channel servo pulse generator. A
// clocked driver feeds tick and position items from a backlog, a clocked
// monitor checks every result transfer against a cycle-free model of the
// shared counter, the clamped channel positions and the pin levels. Timing
// registers are reprogrammed over the APB port between phases, including
// frame lengths shortened in the middle of a frame.
// ----------------------------------------------------------------------------
module tb_multi_channel_servo_pulse_generator;

    timeunit 1ns;
    timeprecision 1ps;

    import mcsp_pkg::*;

    localparam int     CLK_PERIOD   = 10;
    localparam int     NCH          = DEF_CHANNELS;
    localparam logic   ACT_TICK     = 1'b0;
    localparam logic   ACT_SETPOS   = 1'b1;
    localparam int     LONG_HOLD    = 150;
    localparam int     DRAIN_CYCLES = 20;
    localparam int     SHORT_FRAME  = 64;
    localparam longint CYCLE_LIMIT  = 6_000_000;

    // ------------------------------------------------------------------------
    // Clock, reset and the signals around the block. Every input starts at a
    // known value so that nothing floats before the first driven edge.
    // ------------------------------------------------------------------------
    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;

    logic              item_valid   = 1'b0;
    logic              item_stall;
    item_t             item         = '0;

    logic              result_valid;
    logic              result_stall = 1'b0;
    result_t           result;

    logic              psel         = 1'b0;
    logic              penable      = 1'b0;
    logic              pwrite       = 1'b0;
    logic [ADDR_W-1:0] paddr        = '0;
    logic [DATA_W-1:0] pwdata       = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    always #(CLK_PERIOD / 2) clk = ~clk;

    multi_channel_servo_pulse_generator #(
        .CHANNELS     (NCH),
        .CENTER_PULSE (DEF_CENTER_PULSE)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // ------------------------------------------------------------------------
    // Shadow of the block: timing registers, the shared tick counter, the
    // stored position of each channel and the current pin levels. They start
    // at the reset values of the block.
    // ------------------------------------------------------------------------
    logic [POS_W-1:0] cfg_min   = MIN_PULSE_RESET;
    logic [POS_W-1:0] cfg_max   = MAX_PULSE_RESET;
    logic [POS_W-1:0] cfg_frame = FRAME_LENGTH_RESET;
    logic [POS_W-1:0] tick_cnt  = '0;
    logic [POS_W-1:0] chan_pos [NCH] = '{default: DEF_CENTER_PULSE};
    logic [NCH-1:0]   pin_lvl   = '1;

    // Items still to be offered, and the results owed for accepted items,
    // oldest first.
    item_t   item_backlog[$];
    result_t levels_due[$];

    int   mismatch_cnt = 0;

    // Idle knobs. The percentages give the chance that a burst of idle
    // cycles starts; the main sequence changes them from phase to phase.
    int   gap_pct    = 0;
    int   stall_pct  = 0;
    int   gap_left   = 0;
    int   stall_left = 0;
    logic hold_go    = 1'b0;
    int   hold_left  = 0;

    // Advance the shadow by one item and return the result it must produce.
    // A tick bumps the counter; reaching the frame length restarts the frame
    // and raises every pin, which takes precedence over any falling pin at
    // the same count. Otherwise pins fall where the stored position equals
    // the count, but only once the count has reached the minimum pulse.
    // A position write is clamped against the minimum first and only then
    // against the maximum, so an inverted window still behaves as defined.
    function automatic result_t predict_levels(input item_t it);
        result_t          r;
        logic [POS_W-1:0] p;
        r = '0;
        if (it.action == ACT_TICK) begin
            tick_cnt = tick_cnt + 1'b1;
            if (tick_cnt == cfg_frame) begin
                tick_cnt      = '0;
                pin_lvl       = '1;
                r.frame_start = 1'b1;
            end else if (tick_cnt >= cfg_min) begin
                for (int i = 0; i < NCH; i++)
                    if (chan_pos[i] == tick_cnt)
                        pin_lvl[i] = 1'b0;
            end
        end else if (it.channel < NCH) begin
            p = it.position;
            if (p < cfg_min)
                p = cfg_min;
            else if (p > cfg_max)
                p = cfg_max;
            chan_pos[it.channel] = p;
        end
        r.pin_levels = PIN_W'(pin_lvl);
        return r;
    endfunction

    function automatic void flag_mismatch(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("[%0t] MISMATCH %s", $time, msg);
    endfunction

    // ------------------------------------------------------------------------
    // Driver. At each rising edge it notes whether the offered item was taken;
    // a taken item goes through the shadow at once, so the expectation is
    // queued in the order of acceptance. A new item is offered only when the
    // old one was taken or nothing was offered, which keeps a stalled payload
    // stable. After a transfer a random idle burst may follow.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        logic took;
        took = item_valid && !item_stall;
        if (!rst_n) begin
            item_valid <= 1'b0;
        end else begin
            if (took) begin
                levels_due.push_back(predict_levels(item));
                if ($urandom_range(99) < gap_pct)
                    gap_left = $urandom_range(6, 1);
            end
            if (!item_valid || took) begin
                if (gap_left != 0 || item_backlog.size() == 0) begin
                    if (gap_left != 0)
                        gap_left--;
                    item_valid <= 1'b0;
                end else begin
                    item       <= item_backlog.pop_front();
                    item_valid <= 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. Every result transfer is matched against the oldest owed
    // result, field by field. The stall it drives comes in random bursts, or
    // stays high for the whole of a long hold so the block backs up.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        result_t want;
        if (!rst_n) begin
            result_stall <= 1'b0;
        end else begin
            if (result_valid && !result_stall) begin
                if (levels_due.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result pin_levels=%02h frame_start=%0b",
                                            result.pin_levels, result.frame_start));
                end else begin
                    want = levels_due.pop_front();
                    if (result.pin_levels !== want.pin_levels)
                        flag_mismatch($sformatf("pin_levels expected %02h got %02h",
                                                want.pin_levels, result.pin_levels));
                    if (result.frame_start !== want.frame_start)
                        flag_mismatch($sformatf("frame_start expected %0b got %0b",
                                                want.frame_start, result.frame_start));
                end
            end
            if (hold_left != 0) begin
                result_stall <= 1'b1;
            end else if (stall_left != 0) begin
                stall_left--;
                result_stall <= 1'b1;
            end else if ($urandom_range(99) < stall_pct) begin
                stall_left = $urandom_range(5);
                result_stall <= 1'b1;
            end else begin
                result_stall <= 1'b0;
            end
        end
    end

    // The long hold is counted here; a one-cycle request from the main
    // sequence starts it.
    always @(posedge clk) begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_go)
            hold_left <= LONG_HOLD;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // The shadow registers follow the APB bus, so they change at the very
    // edge at which the block takes a write. Unknown addresses are ignored.
    always @(posedge clk) begin
        if (rst_n && psel && penable && pwrite && pready) begin
            case (reg_index_t'(paddr[3:2]))
                REG_MIN_PULSE:    cfg_min   <= pwdata[POS_W-1:0];
                REG_MAX_PULSE:    cfg_max   <= pwdata[POS_W-1:0];
                REG_FRAME_LENGTH: cfg_frame <= pwdata[POS_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers. The main sequence works at falling edges, so its
    // queue updates never share a time step with the clocked processes.
    // ------------------------------------------------------------------------

    // A tick carries random junk in the fields it does not use.
    function automatic item_t tick_item();
        item_t it;
        it.action   = ACT_TICK;
        it.channel  = CHAN_W'($urandom);
        it.position = POS_W'($urandom);
        return it;
    endfunction

    function automatic item_t position_item(input int ch, input int pos);
        item_t it;
        it.action   = ACT_SETPOS;
        it.channel  = CHAN_W'(ch);
        it.position = POS_W'(pos);
        return it;
    endfunction

    // APB write: setup cycle, then access cycle; pready is always high, so the
    // register is written at the edge that ends the access cycle.
    task automatic reg_write(input reg_index_t idx, input logic [DATA_W-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // Random upper bits check that only the low 16 bits of each write count.
    task automatic load_timing(input int mn, input int mx, input int fr);
        reg_write(REG_MIN_PULSE,    {16'($urandom), POS_W'(mn)});
        reg_write(REG_MAX_PULSE,    {16'($urandom), POS_W'(mx)});
        reg_write(REG_FRAME_LENGTH, {16'($urandom), POS_W'(fr)});
    endtask

    // Block until every item has been offered, taken and answered.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (item_backlog.size() != 0 || item_valid || levels_due.size() != 0);
    endtask

    // Tick on to the next frame restart, so the counter is back at zero
    // before the frame length changes. Lowering the frame length below the
    // count would otherwise cost a full 16-bit wrap. When the rest of the
    // frame is long, the frame length is first cut to one past the current
    // count, so a single tick restarts the frame.
    task automatic finish_frame();
        int n;
        wait_idle();
        n = int'(POS_W'(cfg_frame - tick_cnt));
        if (n == 0)
            n = 65536;
        if (n > SHORT_FRAME) begin
            reg_write(REG_FRAME_LENGTH, DATA_W'(POS_W'(tick_cnt + 1'b1)));
            n = 1;
        end
        repeat (n)
            item_backlog.push_back(tick_item());
        wait_idle();
    endtask

    // Random traffic shaped by the current timing: most positions land near
    // the clamp window and at most two past the frame length so that pins
    // really fall, the rest are full-range values and the two extremes. One
    // position write in ten goes to a channel that does not exist.
    task automatic queue_random(input int n, input int tick_pct);
        int lo;
        int hi;
        int ch;
        int pos;
        lo = (cfg_min < cfg_max) ? int'(cfg_min) : int'(cfg_max);
        hi = (cfg_min < cfg_max) ? int'(cfg_max) : int'(cfg_min);
        lo = (lo > 3) ? lo - 3 : 0;
        hi = (hi < 65532) ? hi + 3 : 65535;
        if (cfg_frame != 0 && hi > int'(cfg_frame) + 2)
            hi = int'(cfg_frame) + 2;
        if (hi < lo)
            hi = lo;
        repeat (n) begin
            if ($urandom_range(99) < tick_pct) begin
                item_backlog.push_back(tick_item());
            end else begin
                ch = ($urandom_range(9) == 0) ? $urandom_range(255, NCH)
                                              : $urandom_range(NCH - 1);
                case ($urandom_range(9))
                    0, 1:    pos = $urandom;
                    2:       pos = 0;
                    3:       pos = 65535;
                    default: pos = $urandom_range(hi, lo);
                endcase
                item_backlog.push_back(position_item(ch, pos));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part under the reset timing (min 100, max 200, frame
        // 2000): clamping from below and above, the exact window edges,
        // writes to channels that do not exist, and plain ticks.
        item_backlog.push_back(tick_item());
        item_backlog.push_back(position_item(0, 0));
        item_backlog.push_back(position_item(1, 65535));
        item_backlog.push_back(position_item(2, 99));
        item_backlog.push_back(position_item(3, 201));
        item_backlog.push_back(position_item(4, 100));
        item_backlog.push_back(position_item(5, 200));
        item_backlog.push_back(position_item(6, 16'h5A5A));
        item_backlog.push_back(position_item(7, 101));
        item_backlog.push_back(position_item(NCH, 120));
        item_backlog.push_back(position_item(255, 0));
        item_backlog.push_back(position_item(128, 16'h8000));
        repeat (3)
            item_backlog.push_back(tick_item());
        wait_idle();

        // A write to the unused register index must leave the timing alone.
        reg_write(REG_NONE, 32'hDEAD_BEEF);
        item_backlog.push_back(tick_item());

        // Random traffic under the reset timing. Part way in, the receiver
        // holds off for a long stretch while items keep coming, so the
        // output buffer fills and the block stalls its input.
        gap_pct   = 15;
        stall_pct = 15;
        queue_random(180, 80);
        repeat (20)
            @(negedge clk);
        hold_go = 1'b1;
        @(negedge clk);
        hold_go = 1'b0;
        finish_frame();

        // Short frames. Positions stored under the old window are kept as
        // they are; the sender pauses half way until everything is answered.
        load_timing(4, 20, 24);
        queue_random(200, 70);
        wait_idle();
        queue_random(200, 70);
        finish_frame();

        // Inverted window: below the minimum stores the minimum, anything
        // else stores the maximum.
        gap_pct   = 25;
        stall_pct = 10;
        load_timing(30, 10, 45);
        queue_random(200, 85);
        finish_frame();

        // Lowest settings with no idling at all: every tick restarts.
        gap_pct   = 0;
        stall_pct = 0;
        load_timing(0, 0, 1);
        queue_random(80, 70);
        finish_frame();

        // Full-range window with a tiny frame and heavy back-pressure.
        gap_pct   = 20;
        stall_pct = 30;
        load_timing(0, 65535, 5);
        queue_random(200, 60);
        finish_frame();

        // Closing stretch without any idling on either side.
        gap_pct   = 0;
        stall_pct = 0;
        load_timing(3, 12, 16);
        queue_random(250, 65);
        wait_idle();

        // Give a stray result time to show up before the verdict.
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (levels_due.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", levels_due.size()));

        if (mismatch_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        longint cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

endmodule

### multi_channel_servo_pulse_generator.f
rtl/mcsp_pkg.sv
rtl/mcsp_cell.sv
rtl/multi_channel_servo_pulse_generator.sv
sim/tb_multi_channel_servo_pulse_generator.sv
